>>> design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants
// Request and response payloads, command codes and capacity register defaults
// for the key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_WIDTH  = 32;
   localparam int DATA_WIDTH = 32;
   localparam int CAP_WIDTH  = 5;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic [KEY_WIDTH-1:0]          key;
      logic signed [DATA_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic signed [DATA_WIDTH-1:0]  data;
   } rsp_type;

endpackage

>>> design/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram: generic single-port-write ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, lru replacement
// Keys and values sit in two rams; valid bits and age ranks in flops. One
// compare unit walks the key ram entry by entry, then a decide step updates
// the age order and writes the rams.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | req_valid req_ready req_payload | in
//  response | rsp_valid rsp_ready rsp_payload | out
//  config   | csr_wr_en csr_wr_data           | in
//
//  A request scans the key ram entry by entry through its single read port,
//  then drains, decides and answers; a get that hits also loads the value.
//  req_ready is high only while idle: one request is in flight at a time.
//  Synchronous reset empties the table and sets capacity to 16.
//  A finished response waits in the output register; the request side stays
//  busy until it can be loaded there.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int EC_W  = (CNT_W > CAP_WIDTH) ? CNT_W : CAP_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_VLOAD,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CAP_WIDTH-1:0]    capacity_ff, capacity_in;
   req_type                 req_ff, req_in;
   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [IDX_W-1:0]        rank_ff [ENTRIES];
   logic [IDX_W-1:0]        rank_in [ENTRIES];
   logic [CNT_W-1:0]        valid_cnt_ff, valid_cnt_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]        hit_rank_ff, hit_rank_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    old_found_ff, old_found_in;
   logic [IDX_W-1:0]        old_idx_ff, old_idx_in;
   logic [IDX_W-1:0]        old_rank_ff, old_rank_in;
   rsp_type                 result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_payload_ff, rsp_payload_in;

   logic                    key_wr_en;
   logic                    val_wr_en;
   logic [IDX_W-1:0]        val_wr_addr;
   logic [KEY_WIDTH-1:0]    key_rd;
   logic [DATA_WIDTH-1:0]   val_rd;

   logic [EC_W-1:0]         eff_cap;
   logic                    evict;
   logic [IDX_W-1:0]        slot;
   logic                    cmp_valid;
   logic [IDX_W-1:0]        cmp_rank;

   // key ram is read at the scan pointer, value ram at the hit entry
   lkvc_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (slot),
      .wr_data (req_ff.key),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd)
   );

   lkvc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (req_ff.value),
      .rd_addr (hit_idx_ff),
      .rd_data (val_rd)
   );

   always_comb begin
      eff_cap = EC_W'(capacity_ff);
      if (eff_cap == '0) begin
         eff_cap = EC_W'(1);
      end else if (eff_cap > EC_W'(ENTRIES)) begin
         eff_cap = EC_W'(ENTRIES);
      end
   end

   // a missing free slot also forces the oldest entry out
   assign evict = ((EC_W'(valid_cnt_ff) >= eff_cap) && old_found_ff) || !free_found_ff;
   assign slot  = (evict && (!free_found_ff || (old_idx_ff < free_idx_ff))) ?
                  old_idx_ff : free_idx_ff;

   assign cmp_valid = valid_ff[cmp_idx_ff];
   assign cmp_rank  = rank_ff[cmp_idx_ff];

   always_comb begin
      state_in       = state_ff;
      capacity_in    = capacity_ff;
      req_in         = req_ff;
      valid_in       = valid_ff;
      rank_in        = rank_ff;
      valid_cnt_in   = valid_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = scan_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_rank_in    = hit_rank_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_rank_in    = old_rank_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      key_wr_en      = 1'b0;
      val_wr_en      = 1'b0;
      val_wr_addr    = hit_idx_ff;

      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
      end

      // compare stage, one entry per cycle
      if (cmp_vld_ff) begin
         if (cmp_valid && (key_rd == req_ff.key) && !hit_ff) begin
            hit_in      = 1'b1;
            hit_idx_in  = cmp_idx_ff;
            hit_rank_in = cmp_rank;
         end
         if (!cmp_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (cmp_valid && (!old_found_ff || (cmp_rank > old_rank_ff))) begin
            old_found_in = 1'b1;
            old_idx_in   = cmp_idx_ff;
            old_rank_in  = cmp_rank;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               scan_idx_in   = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               old_found_in  = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            result_in.found = hit_ff;
            result_in.data  = req_ff.value;
            state_in        = ST_DONE;
            if (hit_ff) begin
               // move the hit entry to the front
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_idx_ff == IDX_W'(i)) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                     rank_in[i] = rank_ff[i] + IDX_W'(1);
                  end
               end
               if (req_ff.cmd == CMD_PUT) begin
                  val_wr_en = 1'b1;
               end else begin
                  state_in = ST_VLOAD;
               end
            end else if (req_ff.cmd == CMD_GET) begin
               result_in.data = '0;
            end else begin
               // insert, evicting the oldest entry when full
               key_wr_en   = 1'b1;
               val_wr_en   = 1'b1;
               val_wr_addr = slot;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot == IDX_W'(i)) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                  end else if (evict && (old_idx_ff == IDX_W'(i))) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + IDX_W'(1);
                  end
               end
               valid_cnt_in = valid_cnt_ff - CNT_W'(evict) + CNT_W'(1);
            end
         end
         ST_VLOAD: begin
            result_in.data = val_rd;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         valid_ff     <= '0;
         valid_cnt_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         valid_cnt_ff <= valid_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
      req_ff         <= req_in;
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_rank_ff    <= hit_rank_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      old_found_ff   <= old_found_in;
      old_idx_ff     <= old_idx_in;
      old_rank_ff    <= old_rank_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(valid_cnt_ff))
      else $error("valid count out of step with valid bits");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(valid_cnt_ff) <= ENTRIES)
      else $error("valid count above table size");

   a_get_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && req_ff.cmd == CMD_GET) |=> $stable(valid_cnt_ff))
      else $error("get changed the table occupancy");

   a_drain_to_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_DECIDE && !cmp_vld_ff))
      else $error("scan did not end cleanly");

endmodule

>>> tb/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the lru key-value cache
// A queue of gets, puts and capacity writes drives the request side. The
// bench keeps its own copy of the table and its age order and checks every
// response against the prediction. Both sides pause and stall at random.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES        = 16;
   localparam int SETTLE_CYCLES  = ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int KEY_POOL       = 24;
   localparam int PHASES         = 12;
   localparam int PHASE_REQS     = 110;

   typedef enum logic {
      OP_REQUEST,
      OP_SET_CAPACITY
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      req_type               req;
      logic [CAP_WIDTH-1:0]  cap;
   } cache_op_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [CAP_WIDTH-1:0] csr_wr_data = CAP_RESET;

   // stimulus and expected responses
   cache_op_type op_q[$];
   rsp_type      cache_answers_q[$];

   // shadow copy of the table
   logic [KEY_WIDTH-1:0]         slot_key   [ENTRIES];
   logic signed [DATA_WIDTH-1:0] slot_value [ENTRIES];
   logic                         slot_live  [ENTRIES];
   int                           slot_rank  [ENTRIES];
   int                           live_count;
   logic [CAP_WIDTH-1:0]         capacity_reg = CAP_RESET;

   int issued      = 0;
   int rsp_count   = 0;
   int errors      = 0;
   int gets        = 0;
   int hits        = 0;
   int evictions   = 0;
   int csr_writes  = 0;
   int send_gap    = 0;
   int send_calm   = 0;
   int quiet       = 0;
   int stall       = 0;
   int rsp_calm    = 0;
   int idle_cycles = 0;

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int usable_entries(logic [CAP_WIDTH-1:0] cap);
      if (cap == 0) return 1;
      if (cap > ENTRIES) return ENTRIES;
      return int'(cap);
   endfunction

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void drop_least_recent();
      int i;
      int oldest;
      oldest = -1;
      for (i = 0; i < ENTRIES; i++)
         if (slot_live[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
            oldest = i;
      if (oldest >= 0) begin
         slot_live[oldest] = 1'b0;
         slot_rank[oldest] = 0;
         if (live_count > 0) live_count--;
         evictions++;
      end
   endfunction

   function automatic rsp_type cache_access(req_type r);
      rsp_type res;
      int      i;
      int      hit;
      int      slot;
      int      old_rank;
      hit  = -1;
      slot = -1;
      res  = '0;
      for (i = 0; i < ENTRIES; i++)
         if (hit < 0 && slot_live[i] && slot_key[i] == r.key) hit = i;
      if (r.cmd == CMD_GET) gets++;
      if (hit >= 0) begin
         if (r.cmd == CMD_PUT) slot_value[hit] = r.value;
         old_rank = slot_rank[hit];
         for (i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != hit && slot_rank[i] < old_rank) slot_rank[i]++;
         slot_rank[hit] = 0;
         res.found = 1'b1;
         res.data  = slot_value[hit];
         hits++;
      end else if (r.cmd == CMD_PUT) begin
         // a lowered capacity only sheds one entry per insert
         if (live_count >= usable_entries(capacity_reg)) drop_least_recent();
         for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && !slot_live[i]) slot = i;
         if (slot < 0) begin
            drop_least_recent();
            for (i = 0; i < ENTRIES; i++)
               if (slot < 0 && !slot_live[i]) slot = i;
            if (slot < 0) slot = 0;
         end
         for (i = 0; i < ENTRIES; i++)
            if (slot_live[i]) slot_rank[i]++;
         slot_live[slot]  = 1'b1;
         slot_key[slot]   = r.key;
         slot_value[slot] = r.value;
         slot_rank[slot]  = 0;
         live_count++;
         res.data = r.value;
      end
      return res;
   endfunction

   task automatic add_req(cmd_type c, logic [KEY_WIDTH-1:0] k,
                          logic signed [DATA_WIDTH-1:0] v);
      cache_op_type op;
      op         = '0;
      op.kind    = OP_REQUEST;
      op.req.cmd = c;
      op.req.key = k;
      op.req.value = v;
      op_q.push_back(op);
   endtask

   task automatic add_cap(logic [CAP_WIDTH-1:0] c);
      cache_op_type op;
      op      = '0;
      op.kind = OP_SET_CAPACITY;
      op.cap  = c;
      op_q.push_back(op);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      logic         nxt_valid;
      logic         nxt_wr;
      cache_op_type head;
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         csr_wr_en   <= 1'b0;
         csr_wr_data <= CAP_RESET;
         quiet       = 0;
      end else begin
         if (!req_valid && !csr_wr_en && issued == rsp_count) quiet++;
         else quiet = 0;
         nxt_valid = req_valid;
         nxt_wr    = 1'b0;
         if (req_valid && req_ready) begin
            cache_answers_q.push_back(cache_access(req_payload));
            issued++;
            send_gap  = pick_gap(send_calm);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (op_q.size() > 0) begin
               head = op_q[0];
               if (head.kind == OP_REQUEST) begin
                  void'(op_q.pop_front());
                  nxt_valid = 1'b1;
                  req_payload <= head.req;
               end else if (quiet >= SETTLE_CYCLES) begin
                  // every response is back and the block has gone idle
                  void'(op_q.pop_front());
                  nxt_wr = 1'b1;
                  csr_wr_data <= head.cap;
                  capacity_reg = head.cap;
                  csr_writes++;
               end
            end
         end
         req_valid <= nxt_valid;
         csr_wr_en <= nxt_wr;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall     = 0;
      end else begin
         nxt_ready = 1'b1;
         if (rsp_valid && rsp_ready) begin
            if (cache_answers_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: expected none, got found=%0b data=%0d",
                        $time, rsp_payload.found, rsp_payload.data);
            end else begin
               want = cache_answers_q.pop_front();
               if (rsp_payload.found !== want.found) begin
                  errors++;
                  $display("%0t: found mismatch on response %0d: expected %0b, got %0b",
                           $time, rsp_count, want.found, rsp_payload.found);
               end
               if (rsp_payload.data !== want.data) begin
                  errors++;
                  $display("%0t: data mismatch on response %0d: expected %0d, got %0d",
                           $time, rsp_count, want.data, rsp_payload.data);
               end
            end
            rsp_count <= rsp_count + 1;
            stall = pick_gap(rsp_calm);
         end
         if (stall > 0) begin
            stall--;
            nxt_ready = 1'b0;
         end
         rsp_ready <= nxt_ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("lru_key_value_cache_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [KEY_WIDTH-1:0]         key_pool [KEY_POOL];
      logic [CAP_WIDTH-1:0]         phase_caps [10];
      logic [CAP_WIDTH-1:0]         cap;
      logic [KEY_WIDTH-1:0]         k;
      logic signed [DATA_WIDTH-1:0] v;
      cmd_type                      c;
      int                           i;
      int                           ph;
      int                           n;
      int                           window;
      int                           base;
      int                           roll;

      for (i = 0; i < ENTRIES; i++) begin
         slot_live[i]  = 1'b0;
         slot_rank[i]  = 0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
      end
      live_count = 0;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

      // extremes, update, miss and ignored value at the reset capacity
      add_req(CMD_GET, 32'h0000_0000, 32'sh0000_0000);
      add_req(CMD_PUT, 32'h0000_0000, 32'sh8000_0000);
      add_req(CMD_PUT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      add_req(CMD_GET, 32'h0000_0000, 32'sh0000_0000);
      add_req(CMD_GET, 32'hFFFF_FFFF, 32'sh0000_0000);
      add_req(CMD_PUT, 32'h0000_0000, -32'sd1);
      add_req(CMD_GET, 32'h0000_0000, 32'sh0000_0000);
      add_req(CMD_GET, 32'h1234_5678, 32'sh0000_0000);
      add_req(CMD_PUT, 32'hA5A5_5A5A, 32'sh0000_0000);
      add_req(CMD_GET, 32'hA5A5_5A5A, 32'sh5A5A_A5A5);
      // capacity dropped below the number of live entries
      add_cap(5'd2);
      add_req(CMD_PUT, 32'h5555_5555, 32'sh2AAA_AAAA);
      add_req(CMD_PUT, 32'hAAAA_AAAA, 32'sh5555_5555);
      add_req(CMD_GET, 32'hFFFF_FFFF, 32'sh0000_0000);
      add_req(CMD_GET, 32'hA5A5_5A5A, 32'sh0000_0000);
      add_req(CMD_PUT, 32'h0F0F_0F0F, 32'shF0F0_F0F0);
      add_req(CMD_GET, 32'h5555_5555, 32'sh0000_0000);
      // zero capacity behaves as one
      add_cap(5'd0);
      add_req(CMD_PUT, 32'h0000_0001, 32'sh0000_0001);
      add_req(CMD_PUT, 32'h8000_0000, 32'sh7FFF_FFFE);
      add_req(CMD_GET, 32'h8000_0000, 32'sh0000_0000);
      add_req(CMD_GET, 32'h0000_0001, 32'sh0000_0000);
      // oversized capacity saturates
      add_cap(5'd31);
      add_req(CMD_PUT, 32'hC3C3_3C3C, 32'sh1234_5678);
      add_req(CMD_GET, 32'h8000_0000, 32'sh0000_0000);

      phase_caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd8, 5'd0, 5'd17, 5'd15, 5'd2, 5'd16};
      for (ph = 0; ph < PHASES; ph++) begin
         cap = (ph < 10) ? phase_caps[ph] : 5'($urandom_range(0, 31));
         add_cap(cap);
         // a key window a little wider than the usable capacity keeps hits and evictions mixed
         window = usable_entries(cap) + $urandom_range(1, 4);
         if (window > KEY_POOL) window = KEY_POOL;
         base = $urandom_range(0, KEY_POOL - window);
         for (n = 0; n < PHASE_REQS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) k = $urandom;
            else k = key_pool[base + $urandom_range(0, window - 1)];
            c = ($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET;
            roll = $urandom_range(0, 99);
            if (roll < 3) v = 32'sh8000_0000;
            else if (roll < 6) v = 32'sh7FFF_FFFF;
            else if (roll < 8) v = -32'sd1;
            else v = $urandom;
            add_req(c, k, v);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (op_q.size() != 0 || req_valid || issued != rsp_count) @(negedge clock);
      repeat (ENTRIES + 10) @(negedge clock);

      if (cache_answers_q.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, cache_answers_q.size());
      end
      $display("ran %0d requests: %0d gets, %0d found, %0d evictions, %0d capacity writes",
               issued, gets, hits, evictions, csr_writes);
      $display("capacities covered zero, one, small, full table and oversized settings");
      if (errors == 0) begin
         $display("lru_key_value_cache_tb: done, clean");
      end else begin
         $display("lru_key_value_cache_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/lkvc_pkg.sv
design/lkvc_ram.sv
design/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
